FILE: hw/rtl/rsa_pkg.sv
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared types and constants for the rotation source address block.
// ----------------------------------------------------------------------------
`default_nettype none

package rsa_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int FRAC_BITS = 14;

  // Widths of the configuration and coordinate fields.
  localparam int DIM_W   = $clog2(MAX_DIM) + 1;
  localparam int COORD_W = $clog2(MAX_DIM);
  localparam int TRIG_W  = 16;
  localparam int SRC_W   = 14;
  localparam int ADDR_W  = 24;

  // Internal arithmetic widths.
  localparam int DELTA_W = DIM_W + 2;
  localparam int PROD_W  = DELTA_W + TRIG_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int DIV_SH  = FRAC_BITS + 1;
  localparam int QUOT_W  = SUM_W - DIV_SH + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_COS    = 2'd2,
    REG_SIN    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [TRIG_W-1:0] cos_q14;
    logic [TRIG_W-1:0] sin_q14;
  } cfg_t;

  // Unsaturated source coordinate pair between the rotation and address units.
  typedef struct packed {
    logic [QUOT_W-1:0] sx;
    logic [QUOT_W-1:0] sy;
  } rot_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rsa_if.sv
// ----------------------------------------------------------------------------
// rsa_pix_if / rsa_src_if
// Valid/ready channels for output pixel coordinates and source results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsa_pix_if
  import rsa_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;

  modport source (output valid, output out_x, output out_y, input ready);
  modport sink   (input valid, input out_x, input out_y, output ready);
endinterface

interface rsa_src_if
  import rsa_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic signed [SRC_W-1:0]  src_x;
  logic signed [SRC_W-1:0]  src_y;
  logic                     inside_res;
  logic [ADDR_W-1:0]        src_address;

  modport source (output valid, output src_x, output src_y, output inside_res,
                  output src_address, input ready);
  modport sink   (input valid, input src_x, input src_y, input inside_res,
                  input src_address, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rsa_cfg_regs.sv
// ----------------------------------------------------------------------------
// rsa_cfg_regs
// Configuration registers: frame size (the low DIM_W bits of the data,
// clamped to the maximum) and the rotation cosine and sine.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_cfg_regs
  import rsa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
    logic [DIM_W-1:0] d;
    d = v[DIM_W-1:0];
    if (d > DIM_W'(MAX_DIM)) begin
      d = DIM_W'(MAX_DIM);
    end
    return d;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width   <= DIM_W'(MAX_DIM);
      cfg.height  <= DIM_W'(MAX_DIM);
      cfg.cos_q14 <= TRIG_W'(1 << FRAC_BITS);
      cfg.sin_q14 <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  cfg.width   <= clamp_dim(cfg_data);
        REG_HEIGHT: cfg.height  <= clamp_dim(cfg_data);
        REG_COS:    cfg.cos_q14 <= cfg_data[TRIG_W-1:0];
        REG_SIN:    cfg.sin_q14 <= cfg_data[TRIG_W-1:0];
        default:    ;
      endcase
    end
  end

  a_width_max: assert property (@(posedge clk) disable iff (rst)
    cfg.width <= DIM_W'(MAX_DIM))
    else $error("frame width above maximum");

  a_height_max: assert property (@(posedge clk) disable iff (rst)
    cfg.height <= DIM_W'(MAX_DIM))
    else $error("frame height above maximum");

endmodule

`default_nettype wire

FILE: hw/rtl/rsa_rotate.sv
// ----------------------------------------------------------------------------
// rsa_rotate
// Four-stage rotation pipeline: centred offsets, four products, the two
// rotated sums, then division by two to the power of FRAC_BITS+1 truncated
// toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_rotate
  import rsa_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cfg_t          cfg,
  rsa_pix_if.sink            pix,
  output logic               rot_valid,
  input  wire logic          rot_ready,
  output rot_t               rot
);

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  logic signed [DELTA_W-1:0] dx, dy;
  logic signed [PROD_W-1:0]  p_xc, p_ys, p_xs, p_yc;
  logic signed [SUM_W-1:0]   nx, ny;
  logic signed [QUOT_W-1:0]  sx, sy;

  logic signed [TRIG_W-1:0]  cos_s, sin_s;
  logic signed [SUM_W-1:0]   bias_x, bias_y, nx_adj, ny_adj;
  logic signed [SUM_W-1:0]   nx_next, ny_next;

  // A stage moves on when it is empty or the stage after it moves on.
  assign en4 = !v4 || rot_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign pix.ready = en1;

  assign cos_s  = $signed(cfg.cos_q14);
  assign sin_s  = $signed(cfg.sin_q14);
  assign bias_x = $signed(SUM_W'(cfg.width) << FRAC_BITS);
  assign bias_y = $signed(SUM_W'(cfg.height) << FRAC_BITS);

  assign nx_next = SUM_W'(p_xc) - SUM_W'(p_ys) + bias_x;
  assign ny_next = SUM_W'(p_xs) + SUM_W'(p_yc) + bias_y;

  // Negative sums are biased up by the divisor less one so that the
  // arithmetic shift truncates toward zero.
  assign nx_adj = nx + (nx[SUM_W-1] ? $signed(SUM_W'((1 << DIV_SH) - 1)) : '0);
  assign ny_adj = ny + (ny[SUM_W-1] ? $signed(SUM_W'((1 << DIV_SH) - 1)) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= pix.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      dx <= $signed({2'b00, pix.out_x, 1'b0}) - $signed({2'b00, cfg.width});
      dy <= $signed({2'b00, pix.out_y, 1'b0}) - $signed({2'b00, cfg.height});
    end
    if (en2) begin
      p_xc <= dx * cos_s;
      p_ys <= dy * sin_s;
      p_xs <= dx * sin_s;
      p_yc <= dy * cos_s;
    end
    if (en3) begin
      nx <= nx_next;
      ny <= ny_next;
    end
    if (en4) begin
      sx <= QUOT_W'(nx_adj >>> DIV_SH);
      sy <= QUOT_W'(ny_adj >>> DIV_SH);
    end
  end

  assign rot_valid = v4;
  assign rot.sx    = sx;
  assign rot.sy    = sy;

endmodule

`default_nettype wire

FILE: hw/rtl/rsa_address.sv
// ----------------------------------------------------------------------------
// rsa_address
// Two-stage address unit: frame test, saturation and row product, then the
// linear address in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_address
  import rsa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic rot_valid,
  output logic      rot_ready,
  input  wire rot_t rot,
  rsa_src_if.source src
);

  localparam int ROW_W = COORD_W + DIM_W;

  function automatic logic [SRC_W-1:0] sat_src(input logic signed [QUOT_W-1:0] v);
    logic [SRC_W-1:0] r;
    if (v > $signed(QUOT_W'((1 << (SRC_W - 1)) - 1))) begin
      r = {1'b0, {(SRC_W-1){1'b1}}};
    end else if (v < -$signed(QUOT_W'(1 << (SRC_W - 1)))) begin
      r = {1'b1, {(SRC_W-1){1'b0}}};
    end else begin
      r = v[SRC_W-1:0];
    end
    return r;
  endfunction

  logic v5, v6;
  logic en5, en6;

  logic signed [QUOT_W-1:0] sx, sy;
  logic                     inside5, inside6;
  logic [SRC_W-1:0]         x5, y5, x6, y6;
  logic [ROW_W-1:0]         row_base;
  logic [COORD_W-1:0]       col5;
  logic [ADDR_W-1:0]        addr6;
  logic                     inside_next;

  assign sx = $signed(rot.sx);
  assign sy = $signed(rot.sy);

  assign inside_next = !sx[QUOT_W-1] && (sx < $signed(QUOT_W'(cfg.width)))
                    && !sy[QUOT_W-1] && (sy < $signed(QUOT_W'(cfg.height)));

  assign en6 = !v6 || src.ready;
  assign en5 = !v5 || en6;
  assign rot_ready = en5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en5) v5 <= rot_valid;
      if (en6) v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      inside5  <= inside_next;
      x5       <= sat_src(sx);
      y5       <= sat_src(sy);
      // Only the low bits matter: inside the frame the row is below MAX_DIM.
      row_base <= sy[COORD_W-1:0] * cfg.width;
      col5     <= sx[COORD_W-1:0];
    end
    if (en6) begin
      inside6 <= inside5;
      x6      <= x5;
      y6      <= y5;
      addr6   <= inside5 ? ADDR_W'(row_base + ROW_W'(col5)) : '0;
    end
  end

  assign src.valid       = v6;
  assign src.src_x       = $signed(x6);
  assign src.src_y       = $signed(y6);
  assign src.inside_res  = inside6;
  assign src.src_address = addr6;

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    src.valid && !src.inside_res |-> src.src_address == '0)
    else $error("address not zero for a source outside the frame");

  a_inside_nonneg: assert property (@(posedge clk) disable iff (rst)
    src.valid && src.inside_res |-> !src.src_x[SRC_W-1] && !src.src_y[SRC_W-1])
    else $error("negative coordinate flagged inside the frame");

endmodule

`default_nettype wire

FILE: hw/rtl/rotation_source_address.sv
// ----------------------------------------------------------------------------
// rotation_source_address
// Nearest-neighbour inverse rotation of output pixel coordinates.
// ----------------------------------------------------------------------------
// The block maps each output pixel coordinate to the source pixel it samples
// when the frame is rotated about its centre, and reports the source column
// and row (saturated to 14 bits), an inside-frame flag (clear means a black
// pixel) and the linear source address, which is zero outside the frame. It
// takes one item per clock when the output is not stalled. Each item passes
// in order through centred offsets, four 15 by 16 bit products, the rotated
// sums, the truncating shift, the frame test with the row product, and the
// address add in the output register. A stalled output holds the pipeline
// back stage by stage; empty stages still fill. The user must write
// configuration only while no item is in flight; the block does not check it.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_source_address
  import rsa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  rsa_pix_if.sink                    pix,
  rsa_src_if.source                  src
);

  cfg_t cfg;
  rot_t rot;
  logic rot_valid;
  logic rot_ready;

  rsa_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rsa_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pix       (pix),
    .rot_valid (rot_valid),
    .rot_ready (rot_ready),
    .rot       (rot)
  );

  rsa_address u_address (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rot_valid (rot_valid),
    .rot_ready (rot_ready),
    .rot       (rot),
    .src       (src)
  );

endmodule

`default_nettype wire
